// ===== src/gaussian_residual_jacobian_assert.svh =====
// assertion macros shared by the gaussian residual and jacobian rtl
`ifndef GAUSSIAN_RESIDUAL_JACOBIAN_ASSERT_SVH
`define GAUSSIAN_RESIDUAL_JACOBIAN_ASSERT_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define GRJ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define GRJ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/grj_pkg.sv =====
// shared constants, types and functions of the gaussian residual and jacobian block
package grj_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAX_SAMPLES_DEF = 4096;
	localparam int IDX_W = 12;
	localparam int DATA_W = 32;
	localparam int POS_W = 31;
	localparam int DIST_W = 34;
	localparam int R_W = 20;
	localparam int R2_W = 23;
	localparam int R_QW = 21;
	localparam int OUT_QW = 33;
	localparam int G_W = 31;
	localparam int TAB_W = 30;

	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [G_W-1:0] Q30_ONE = G_W'(1 << 30);
	localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	typedef enum logic [1:0] {
		REG_AMPLITUDE = 2'd0,
		REG_CENTER    = 2'd1,
		REG_WIDTH     = 2'd2
	} reg_idx_t;

	// sample data riding along the distance divider
	typedef struct packed {
		logic              neg;
		logic [DATA_W-1:0] y;
		logic [POS_W-1:0]  sig;
	} grj_samp_t;

	// sample data riding along the exponential pipe
	typedef struct packed {
		logic              neg;
		logic [R_W-1:0]    r;
		logic [R2_W-1:0]   r2;
		logic [DATA_W-1:0] y;
		logic [POS_W-1:0]  sig;
	} grj_side_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bits;
		rem = x;
		res = '0;
		bits = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bits) begin
				rem = rem - (res + bits);
				res = (res >> 1) + bits;
			end else begin
				res = res >> 1;
			end
			bits = bits >> 2;
		end
		return res;
	endfunction

	// factors 2^(-2^-(j+1)) in q30, by repeated square roots
	function automatic logic [FRAC_BITS*TAB_W-1:0] build_pow_tab();
		logic [63:0] v;
		logic [FRAC_BITS*TAB_W-1:0] tab;
		v = 64'd1 << 29;
		tab = '0;
		for (int i = 0; i < FRAC_BITS; i++) begin
			v = isqrt64(v << 30);
			tab[i*TAB_W +: TAB_W] = v[TAB_W-1:0];
		end
		return tab;
	endfunction

	localparam logic [FRAC_BITS*TAB_W-1:0] POW_TAB = build_pow_tab();

	// round half up from the doubled quotient, apply sign, saturate
	function automatic logic [31:0] sat_out(input logic [OUT_QW-1:0] quo, input logic ovf,
		input logic neg);
		logic [OUT_QW:0] q;
		logic [OUT_QW:0] nq;
		logic [31:0] res;
		q = ({1'b0, quo} + (OUT_QW+1)'(1)) >> 1;
		nq = -q;
		if (ovf) begin
			res = neg ? SAT_MIN : SAT_MAX;
		end else if (neg) begin
			res = (q > (OUT_QW+1)'(SAT_MIN)) ? SAT_MIN : nq[31:0];
		end else begin
			res = (q > (OUT_QW+1)'(SAT_MAX)) ? SAT_MAX : q[31:0];
		end
		return res;
	endfunction

endpackage

// ===== src/gaussian_residual_jacobian.sv =====
// done follows a taken start through the distance divider, the exponential pipe and the output dividers
// throughput: one sample per cycle; busy stays low, every stage advances each cycle
// the depth comes from the two bit-serial divider pipes (21 and 33 stages)
// and the 16-stage exponential factor chain
// reset: arst_n clears all valid bits and loads amplitude 1.0, center 0, width 1.0
`include "gaussian_residual_jacobian_assert.svh"

module gaussian_residual_jacobian import grj_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [IDX_W-1:0]         sample_index,
	input  logic signed [DATA_W-1:0] measured,
	input  logic [POS_W-1:0]         uncertainty,
	output logic                     done,
	output logic signed [DATA_W-1:0] residual,
	output logic signed [DATA_W-1:0] jac_amplitude,
	output logic signed [DATA_W-1:0] jac_center,
	output logic signed [DATA_W-1:0] jac_width,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [3:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	localparam int IDX_LIM = (MAX_SAMPLES - 1 > (1 << IDX_W) - 1) ?
		(1 << IDX_W) - 1 : MAX_SAMPLES - 1;
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(IDX_LIM);
	localparam logic [R_W-1:0] RCAP = R_W'(1 << (FRAC_BITS + 3));
	localparam logic [R_QW-1:0] CAP_Q2 = R_QW'((1 << (R_QW - 1)) - 1);
	localparam int RN_W = 32 + FRAC_BITS + 1;
	localparam int P2_W = 32 + R_W - 1;
	localparam int P3_W = 32 + R2_W - 1;
	localparam int DEN_W = 2 * POS_W;

	// configuration registers
	logic signed [DATA_W-1:0] amp_q;
	logic signed [DATA_W-1:0] center_q;
	logic [POS_W-1:0]         width_q;
	logic [POS_W-1:0]         w_fix;
	logic                     cfg_wr;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign w_fix  = (width_q == '0) ? POS_W'(1) : width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q    <= DATA_W'(65536);
			center_q <= '0;
			width_q  <= POS_W'(65536);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_AMPLITUDE: amp_q    <= pwdata;
				REG_CENTER:    center_q <= pwdata;
				REG_WIDTH:     width_q  <= pwdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_AMPLITUDE: prdata = amp_q;
			REG_CENTER:    prdata = center_q;
			REG_WIDTH:     prdata = {1'b0, width_q};
			default:       prdata = '0;
		endcase
	end

	// stage 1: distance from the center
	logic [IDX_W-1:0]         idx_c;
	logic signed [DIST_W-1:0] d_c;
	logic [DIST_W-1:0]        dabs_c;
	grj_samp_t                samp_c;
	logic                     valid_s1;
	logic [31:0]              mag_s1;
	grj_samp_t                samp_s1;

	assign idx_c  = (sample_index > IDX_MAX) ? IDX_MAX : sample_index;
	assign d_c    = $signed({{(DIST_W-IDX_W-FRAC_BITS){1'b0}}, idx_c, {FRAC_BITS{1'b0}}})
		- DIST_W'(center_q);
	assign dabs_c = d_c[DIST_W-1] ? DIST_W'(-d_c) : DIST_W'(d_c);

	always_comb begin
		samp_c.neg = d_c[DIST_W-1];
		samp_c.y   = measured;
		samp_c.sig = (uncertainty == '0) ? POS_W'(1) : uncertainty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1  <= dabs_c[31:0];
		samp_s1 <= samp_c;
	end

	// distance in widths: |d| * 2^(F+1) / width
	logic                        rd_valid;
	logic [R_QW-1:0]             rd_quo;
	logic                        rd_ovf;
	logic [$bits(grj_samp_t)-1:0] rd_side;
	grj_samp_t                   samp_r;

	grj_divpipe #(
		.NW(RN_W),
		.DW(POS_W),
		.QW(R_QW),
		.SW($bits(grj_samp_t))
	) u_rdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_num   ({mag_s1, {(FRAC_BITS+1){1'b0}}}),
		.in_den   (w_fix),
		.in_side  (samp_s1),
		.out_valid(rd_valid),
		.out_quo  (rd_quo),
		.out_ovf  (rd_ovf),
		.out_side (rd_side)
	);

	assign samp_r = rd_side;

	// stage 2: round, far tail cap at 8.0
	logic            cap_c;
	logic [R_W-1:0]  r_c;
	logic            valid_s2;
	logic [R_W-1:0]  r_s2;
	logic            cap_s2;
	grj_samp_t       samp_s2;

	assign cap_c = rd_ovf || (rd_quo >= CAP_Q2);
	assign r_c   = cap_c ? RCAP : R_W'(((R_QW+1)'(rd_quo) + (R_QW+1)'(1)) >> 1);

	// stage 3: square
	logic [39:0]     sq_c;
	logic            valid_s3;
	logic [39:0]     sq_s3;
	logic            cap_s3;
	grj_samp_t       samp_s3;
	logic [R_W-1:0]  r_s3;

	assign sq_c = r_s2 * r_s2;

	// stage 4: a = d^2/(2 w^2), times log2 e
	logic [21:0]     a_c;
	logic [R2_W-1:0] r2_c;
	logic [52:0]     prod_c;
	logic            valid_s4;
	logic [52:0]     prod_s4;
	logic [R_W-1:0]  r_s4;
	logic [R2_W-1:0] r2_s4;
	logic            cap_s4;
	grj_samp_t       samp_s4;

	assign a_c    = 22'((sq_s3 + 40'(1 << FRAC_BITS)) >> (FRAC_BITS + 1));
	assign r2_c   = R2_W'((sq_s3 + 40'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
	assign prod_c = 53'(a_c) * 53'(LOG2E_Q30);

	// stage 5: split exponent into shift and fraction
	logic [22:0]          t_c;
	logic [6:0]           k_c;
	grj_side_t            side_c;
	logic                 valid_s5;
	logic [FRAC_BITS-1:0] frac_s5;
	logic [4:0]           shift_s5;
	logic                 zero_s5;
	grj_side_t            side_s5;

	assign t_c = 23'((prod_s4 + 53'(1 << 29)) >> 30);
	assign k_c = t_c[22:FRAC_BITS];

	always_comb begin
		side_c.neg = samp_s4.neg;
		side_c.r   = r_s4;
		side_c.r2  = r2_s4;
		side_c.y   = samp_s4.y;
		side_c.sig = samp_s4.sig;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s2 <= rd_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		r_s2     <= r_c;
		cap_s2   <= cap_c;
		samp_s2  <= samp_r;
		sq_s3    <= sq_c;
		r_s3     <= r_s2;
		cap_s3   <= cap_s2;
		samp_s3  <= samp_s2;
		prod_s4  <= prod_c;
		r_s4     <= r_s3;
		r2_s4    <= r2_c;
		cap_s4   <= cap_s3;
		samp_s4  <= samp_s3;
		frac_s5  <= t_c[FRAC_BITS-1:0];
		shift_s5 <= k_c[4:0];
		zero_s5  <= cap_s4 || (k_c >= 7'd31);
		side_s5  <= side_c;
	end

	// gaussian g in q1.30
	logic                         exp_valid;
	logic [G_W-1:0]               exp_g30;
	logic [$bits(grj_side_t)-1:0] exp_side;
	grj_side_t                    side_e;

	grj_exp_pipe #(
		.SW($bits(grj_side_t))
	) u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s5),
		.in_frac  (frac_s5),
		.in_shift (shift_s5),
		.in_zero  (zero_s5),
		.in_side  (side_s5),
		.out_valid(exp_valid),
		.out_g30  (exp_g30),
		.out_side (exp_side)
	);

	assign side_e = exp_side;

	// stage 6: b*g and width*sigma
	logic signed [63:0] bg30_c;
	logic [DEN_W-1:0]   den_c;
	logic               valid_s6;
	logic signed [63:0] bg30_s6;
	logic [DEN_W-1:0]   den_s6;
	logic [G_W-1:0]     g30_s6;
	grj_side_t          side_s6;

	assign bg30_c = amp_q * $signed({1'b0, exp_g30});
	assign den_c  = w_fix * side_e.sig;

	// stage 7: rounded b*g and the residual numerator
	logic signed [63:0] bgr_c;
	logic signed [63:0] num0_c;
	logic               valid_s7;
	logic signed [32:0] bg_s7;
	logic signed [63:0] num0_s7;
	logic [DEN_W-1:0]   den_s7;
	logic [G_W-1:0]     g30_s7;
	grj_side_t          side_s7;

	assign bgr_c  = (bg30_s6 + 64'sd536870912) >>> 30;
	assign num0_c = (64'sd1 <<< (FRAC_BITS + 30)) + bg30_s6
		- (64'($signed(side_s6.y)) <<< 30);

	// stage 8: magnitudes
	logic [32:0]        bgabs_c;
	logic [63:0]        n0abs_c;
	logic               valid_s8;
	logic [31:0]        bgmag_s8;
	logic               bgneg_s8;
	logic [49:0]        n0mag_s8;
	logic               n0neg_s8;
	logic [DEN_W-1:0]   den_s8;
	logic [G_W-1:0]     g30_s8;
	grj_side_t          side_s8;

	assign bgabs_c = bg_s7[32] ? 33'(-bg_s7) : 33'(bg_s7);
	assign n0abs_c = num0_s7[63] ? 64'(-num0_s7) : 64'(num0_s7);

	// stage 9: jacobian numerators
	logic [P2_W-1:0]    p2_c;
	logic [P3_W-1:0]    p3_c;
	logic               valid_s9;
	logic [P2_W-1:0]    p2_s9;
	logic [P3_W-1:0]    p3_s9;
	logic               n2neg_s9;
	logic               n3neg_s9;
	logic [49:0]        n0mag_s9;
	logic               n0neg_s9;
	logic [DEN_W-1:0]   den_s9;
	logic [G_W-1:0]     g30_s9;
	logic [POS_W-1:0]   sig_s9;

	assign p2_c = bgmag_s8 * side_s8.r;
	assign p3_c = bgmag_s8 * side_s8.r2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			valid_s6 <= exp_valid;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		bg30_s6  <= bg30_c;
		den_s6   <= den_c;
		g30_s6   <= exp_g30;
		side_s6  <= side_e;
		bg_s7    <= bgr_c[32:0];
		num0_s7  <= num0_c;
		den_s7   <= den_s6;
		g30_s7   <= g30_s6;
		side_s7  <= side_s6;
		bgmag_s8 <= bgabs_c[31:0];
		bgneg_s8 <= bg_s7[32];
		n0mag_s8 <= n0abs_c[62:13];
		n0neg_s8 <= num0_s7[63];
		den_s8   <= den_s7;
		g30_s8   <= g30_s7;
		side_s8  <= side_s7;
		p2_s9    <= p2_c;
		p3_s9    <= p3_c;
		n2neg_s9 <= bgneg_s8 ^ side_s8.neg;
		n3neg_s9 <= bgneg_s8;
		n0mag_s9 <= n0mag_s8;
		n0neg_s9 <= n0neg_s8;
		den_s9   <= den_s8;
		g30_s9   <= g30_s8;
		sig_s9   <= side_s8.sig;
	end

	// four output division lanes
	logic [3:0]        lane_valid;
	logic [3:0]        lane_ovf;
	logic [3:0]        lane_neg;
	logic [OUT_QW-1:0] lane_quo [4];

	grj_divpipe #(.NW(50), .DW(POS_W), .QW(OUT_QW), .SW(1)) u_div_res (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s9),
		.in_num   (n0mag_s9),
		.in_den   (sig_s9),
		.in_side  (n0neg_s9),
		.out_valid(lane_valid[0]),
		.out_quo  (lane_quo[0]),
		.out_ovf  (lane_ovf[0]),
		.out_side (lane_neg[0])
	);

	grj_divpipe #(.NW(G_W + 2*FRAC_BITS - 29), .DW(POS_W), .QW(OUT_QW), .SW(1)) u_div_amp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s9),
		.in_num   ({g30_s9, {(2*FRAC_BITS-29){1'b0}}}),
		.in_den   (sig_s9),
		.in_side  (1'b0),
		.out_valid(lane_valid[1]),
		.out_quo  (lane_quo[1]),
		.out_ovf  (lane_ovf[1]),
		.out_side (lane_neg[1])
	);

	grj_divpipe #(.NW(P2_W + FRAC_BITS + 1), .DW(DEN_W), .QW(OUT_QW), .SW(1)) u_div_cen (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s9),
		.in_num   ({p2_s9, {(FRAC_BITS+1){1'b0}}}),
		.in_den   (den_s9),
		.in_side  (n2neg_s9),
		.out_valid(lane_valid[2]),
		.out_quo  (lane_quo[2]),
		.out_ovf  (lane_ovf[2]),
		.out_side (lane_neg[2])
	);

	grj_divpipe #(.NW(P3_W + FRAC_BITS + 1), .DW(DEN_W), .QW(OUT_QW), .SW(1)) u_div_wid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s9),
		.in_num   ({p3_s9, {(FRAC_BITS+1){1'b0}}}),
		.in_den   (den_s9),
		.in_side  (n3neg_s9),
		.out_valid(lane_valid[3]),
		.out_quo  (lane_quo[3]),
		.out_ovf  (lane_ovf[3]),
		.out_side (lane_neg[3])
	);

	// output register, saturating the lane quotients
	logic              done_q;
	logic [DATA_W-1:0] res_q;
	logic [DATA_W-1:0] jamp_q;
	logic [DATA_W-1:0] jcen_q;
	logic [DATA_W-1:0] jwid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= lane_valid[0];
		end
	end

	always_ff @(posedge clk) begin
		res_q  <= sat_out(lane_quo[0], lane_ovf[0], lane_neg[0]);
		jamp_q <= sat_out(lane_quo[1], lane_ovf[1], lane_neg[1]);
		jcen_q <= sat_out(lane_quo[2], lane_ovf[2], lane_neg[2]);
		jwid_q <= sat_out(lane_quo[3], lane_ovf[3], lane_neg[3]);
	end

	assign done          = done_q;
	assign residual      = res_q;
	assign jac_amplitude = jamp_q;
	assign jac_center    = jcen_q;
	assign jac_width     = jwid_q;

	`GRJ_ASSERT_SAME(a_r_capped, valid_s2, r_s2 <= RCAP, "distance ratio above the tail cap")
	`GRJ_ASSERT_SAME(a_g_bound, exp_valid, exp_g30 <= Q30_ONE, "gaussian above one")
	`GRJ_ASSERT_SAME(a_lanes_aligned, lane_valid[0], lane_valid[3:1] == 3'b111, "lanes skewed")
	`GRJ_ASSERT_NEXT(a_done_follows, lane_valid[0], done, "result transfer lost")

endmodule

// ===== src/grj_divpipe.sv =====
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module grj_divpipe import grj_pkg::*; #(
	parameter int NW = 49,
	parameter int DW = 31,
	parameter int QW = 21,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [QW-1:0] out_quo,
	output logic          out_ovf,
	output logic [SW-1:0] out_side
);

	localparam int HW = NW - QW;
	localparam int CW = (HW > DW) ? HW : DW;

	logic          valid_s [QW+1];
	logic [DW-1:0] rem_s   [QW+1];
	logic [DW-1:0] den_s   [QW+1];
	logic [QW-1:0] lo_s    [QW+1];
	logic [QW-1:0] quo_s   [QW+1];
	logic          ovf_s   [QW+1];
	logic [SW-1:0] side_s  [QW+1];

	logic [CW-1:0] hi_ext;
	logic [CW-1:0] den_ext;
	logic          ovf_c;

	// quotient does not fit when the top part already reaches the divisor
	assign hi_ext  = CW'(in_num[NW-1:QW]);
	assign den_ext = CW'(in_den);
	assign ovf_c   = hi_ext >= den_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= ovf_c ? '0 : hi_ext[DW-1:0];
		den_s[0]  <= in_den;
		lo_s[0]   <= in_num[QW-1:0];
		quo_s[0]  <= '0;
		ovf_s[0]  <= ovf_c;
		side_s[0] <= in_side;
	end

	for (genvar b = 1; b <= QW; b++) begin : g_step
		logic [DW:0] trial;
		logic        ge;

		assign trial = {rem_s[b-1], lo_s[b-1][QW-1]};
		assign ge    = trial >= {1'b0, den_s[b-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[b] <= 1'b0;
			end else begin
				valid_s[b] <= valid_s[b-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[b]  <= ge ? DW'(trial - {1'b0, den_s[b-1]}) : trial[DW-1:0];
			den_s[b]  <= den_s[b-1];
			lo_s[b]   <= lo_s[b-1] << 1;
			quo_s[b]  <= {quo_s[b-1][QW-2:0], ge};
			ovf_s[b]  <= ovf_s[b-1];
			side_s[b] <= side_s[b-1];
		end
	end

	assign out_valid = valid_s[QW];
	assign out_quo   = quo_s[QW];
	assign out_ovf   = ovf_s[QW];
	assign out_side  = side_s[QW];

endmodule

// ===== src/grj_exp_pipe.sv =====
// pipelined 2^-t: one table factor per fraction bit, then a rounding shift
module grj_exp_pipe import grj_pkg::*; #(
	parameter int SW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [FRAC_BITS-1:0] in_frac,
	input  logic [4:0]           in_shift,
	input  logic                 in_zero,
	input  logic [SW-1:0]        in_side,
	output logic                 out_valid,
	output logic [G_W-1:0]       out_g30,
	output logic [SW-1:0]        out_side
);

	logic                 valid_s [FRAC_BITS+1];
	logic [G_W-1:0]       p_s     [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] frac_s  [FRAC_BITS+1];
	logic [4:0]           shift_s [FRAC_BITS+1];
	logic                 zero_s  [FRAC_BITS+1];
	logic [SW-1:0]        side_s  [FRAC_BITS+1];

	logic                 valid_q;
	logic [G_W-1:0]       g30_q;
	logic [SW-1:0]        side_q;

	logic [G_W:0]         rnd_c;
	logic [G_W-1:0]       g30_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		p_s[0]     <= Q30_ONE;
		frac_s[0]  <= in_frac;
		shift_s[0] <= in_shift;
		zero_s[0]  <= in_zero;
		side_s[0]  <= in_side;
	end

	for (genvar j = 0; j < FRAC_BITS; j++) begin : g_fac
		logic [60:0]    prod;
		logic [G_W-1:0] scaled;

		// msb of the fraction first, weight 2^-(j+1)
		assign prod   = 61'(p_s[j]) * 61'(POW_TAB[j*TAB_W +: TAB_W]);
		assign scaled = G_W'((prod + 61'(1 << 29)) >> 30);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j+1] <= 1'b0;
			end else begin
				valid_s[j+1] <= valid_s[j];
			end
		end

		always_ff @(posedge clk) begin
			p_s[j+1]     <= frac_s[j][FRAC_BITS-1-j] ? scaled : p_s[j];
			frac_s[j+1]  <= frac_s[j];
			shift_s[j+1] <= shift_s[j];
			zero_s[j+1]  <= zero_s[j];
			side_s[j+1]  <= side_s[j];
		end
	end

	// integer part of the exponent: shift right, rounding half up
	assign rnd_c = {1'b0, p_s[FRAC_BITS]} + (((G_W+1)'(1) << shift_s[FRAC_BITS]) >> 1);
	assign g30_c = zero_s[FRAC_BITS] ? '0 : G_W'(rnd_c >> shift_s[FRAC_BITS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_s[FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		g30_q  <= g30_c;
		side_q <= side_s[FRAC_BITS];
	end

	assign out_valid = valid_q;
	assign out_g30   = g30_q;
	assign out_side  = side_q;

endmodule

// ===== bench/gaussian_residual_jacobian_tb.sv =====
// testbench for the gaussian residual and jacobian evaluator: directed and random samples, self-checking
module gaussian_residual_jacobian_tb;
	import grj_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam longint unsigned QCAP = 64'd1 << 32;
	localparam int LATENCY = 84;

	typedef struct {
		logic [31:0] residual;
		logic [31:0] jac_amplitude;
		logic [31:0] jac_center;
		logic [31:0] jac_width;
	} grad_t;

	class fit_scoreboard;
		longint amp;
		longint cen;
		longint unsigned wid;
		longint unsigned exp_tab[16];
		grad_t pending[$];
		int unsigned errors;
		int unsigned checked;

		function new();
			longint unsigned v;
			v = 64'd1 << 29;
			for (int i = 0; i < 16; i++) begin
				v = int_sqrt(v << 30);
				exp_tab[i] = v;
			end
			amp = 65536;
			cen = 0;
			wid = 65536;
			errors = 0;
			checked = 0;
		endfunction

		function longint unsigned int_sqrt(longint unsigned x);
			longint unsigned res;
			longint unsigned cand;
			res = 0;
			for (int b = 31; b >= 0; b--) begin
				cand = res | (64'd1 << b);
				if (cand * cand <= x)
					res = cand;
			end
			return res;
		endfunction

		// rounded m*2^e/den, capped
		function longint unsigned scaled_quot(longint unsigned m, longint unsigned den, int e);
			longint unsigned q;
			longint unsigned rm;
			if (e < 0) begin
				den = den << (-e);
				e = 0;
			end
			q = m / den;
			rm = m % den;
			if (q >= (QCAP << 1))
				return QCAP;
			for (int i = 0; i <= e; i++) begin
				rm = rm << 1;
				q = q << 1;
				if (rm >= den) begin
					rm = rm - den;
					q = q | 1;
				end
				if (q >= (QCAP << 1))
					return QCAP;
			end
			q = (q + 1) >> 1;
			return (q >= QCAP) ? QCAP : q;
		endfunction

		function logic [31:0] sat_quot(longint num, longint unsigned den, int e);
			longint unsigned q;
			longint v;
			q = scaled_quot((num < 0) ? longint'(-num) : num, den, e);
			if (num < 0)
				v = (q > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(q);
			else
				v = (q > 64'h7fff_ffff) ? 64'sh7fff_ffff : longint'(q);
			return v[31:0];
		endfunction

		// 2^-t in q30, t with 16 fraction bits
		function longint unsigned pow2_neg(longint unsigned t);
			longint unsigned k;
			longint unsigned p;
			k = t >> FRAC_BITS;
			p = 64'd1 << 30;
			if (k >= 31)
				return 0;
			for (int j = 0; j < FRAC_BITS; j++) begin
				if (t[FRAC_BITS-1-j])
					p = (p * exp_tab[j] + (64'd1 << 29)) >> 30;
			end
			if (k == 0)
				return p;
			return (p + (64'd1 << (k - 1))) >> k;
		endfunction

		function void set_reg(logic [1:0] ri, logic [31:0] v);
			case (ri)
				REG_AMPLITUDE: amp = longint'(signed'(v));
				REG_CENTER: cen = longint'(signed'(v));
				REG_WIDTH: wid = v[30:0];
				default: ;
			endcase
		endfunction

		function void note_sample(logic [11:0] idx, logic [31:0] meas, logic [30:0] unc);
			longint unsigned sig, w, r, r2, a, g30, t;
			longint y, d, bg30, bg, rs, num;
			grad_t e;
			y = longint'(signed'(meas));
			sig = (unc == 0) ? 1 : unc;
			w = (wid == 0) ? 1 : wid;
			d = (longint'(idx) <<< FRAC_BITS) - cen;
			r = scaled_quot((d < 0) ? longint'(-d) : d, w, FRAC_BITS);
			if (r >= (64'd8 << FRAC_BITS)) begin
				// far tail: gaussian taken as zero
				r = 64'd8 << FRAC_BITS;
				g30 = 0;
			end else begin
				a = (r * r + (64'd1 << FRAC_BITS)) >> (FRAC_BITS + 1);
				t = (a * 64'd1549082005 + (64'd1 << 29)) >> 30;
				g30 = pow2_neg(t);
			end
			r2 = (r * r + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			bg30 = amp * longint'(g30);
			bg = (bg30 + (64'sd1 << 29)) >>> 30;
			rs = (d < 0) ? -longint'(r) : longint'(r);
			num = (64'sd1 << (FRAC_BITS + 30)) + bg30 - (y <<< 30);
			e.residual = sat_quot(num, sig, FRAC_BITS - 30);
			e.jac_amplitude = sat_quot(longint'(g30), sig, 2 * FRAC_BITS - 30);
			e.jac_center = sat_quot(bg * rs, w * sig, FRAC_BITS);
			e.jac_width = sat_quot(bg * longint'(r2), w * sig, FRAC_BITS);
			pending.push_back(e);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("mismatch %s: got %h expected %h", what, got, want);
		endtask

		task check_result(grad_t got);
			grad_t e;
			checked++;
			if (pending.size() == 0) begin
				report("unexpected result", got.residual, 32'h0);
				return;
			end
			e = pending.pop_front();
			if (got.residual !== e.residual)
				report("residual", got.residual, e.residual);
			if (got.jac_amplitude !== e.jac_amplitude)
				report("jac_amplitude", got.jac_amplitude, e.jac_amplitude);
			if (got.jac_center !== e.jac_center)
				report("jac_center", got.jac_center, e.jac_center);
			if (got.jac_width !== e.jac_width)
				report("jac_width", got.jac_width, e.jac_width);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [IDX_W-1:0] sample_index;
	logic signed [DATA_W-1:0] measured;
	logic [POS_W-1:0] uncertainty;
	logic done;
	logic signed [DATA_W-1:0] residual;
	logic signed [DATA_W-1:0] jac_amplitude;
	logic signed [DATA_W-1:0] jac_center;
	logic signed [DATA_W-1:0] jac_width;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	fit_scoreboard sb = new();
	int unsigned sent = 0;
	int unsigned phases = 0;
	bit gaps_on = 1;

	gaussian_residual_jacobian dut (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		grad_t got;
		if (arst_n && done) begin
			got.residual = residual;
			got.jac_amplitude = jac_amplitude;
			got.jac_center = jac_center;
			got.jac_width = jac_width;
			sb.check_result(got);
		end
	end

	task cfg_write(input logic [1:0] ri, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {ri, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(ri, v);
	endtask

	// wait for the pipe to empty before touching registers
	task drain();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 6) @(posedge clk);
	endtask

	task configure(input logic [31:0] a, input logic [31:0] c, input logic [31:0] w);
		drain();
		cfg_write(REG_AMPLITUDE, a);
		cfg_write(REG_CENTER, c);
		cfg_write(REG_WIDTH, w);
		phases++;
	endtask

	task send(input logic [11:0] idx, input logic [31:0] meas, input logic [30:0] unc);
		int g;
		int pick;
		start <= 1'b1;
		sample_index <= idx;
		measured <= meas;
		uncertainty <= unc;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_sample(idx, meas, unc);
		sent++;
		pick = $urandom_range(0, 99);
		g = 0;
		if (gaps_on) begin
			if (pick >= 90)
				g = $urandom_range(10, 60);
			else if (pick >= 50)
				g = $urandom_range(1, 3);
		end
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic logic [30:0] rand_unc();
		int m;
		m = $urandom_range(0, 9);
		if (m == 0)
			return 31'($urandom_range(0, 2));
		if (m < 4)
			return 31'($urandom);
		if (m == 4)
			return 31'h7fff_ffff;
		return 31'($urandom_range(1 << 12, 1 << 20));
	endfunction

	function automatic logic [31:0] rand_meas();
		if ($urandom_range(0, 2) == 0)
			return $urandom;
		return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 17);
	endfunction

	task random_phase(input int n);
		int ci;
		int spread;
		int idx;
		for (int i = 0; i < n; i++) begin
			// mostly samples near the peak, where the gaussian is not negligible
			if ($urandom_range(0, 9) < 7) begin
				ci = int'(sb.cen >>> FRAC_BITS);
				spread = int'(sb.wid >> FRAC_BITS) * 3 + 3;
				if (spread > 4096)
					spread = 4096;
				idx = ci + $urandom_range(0, 2 * spread) - spread;
				if (idx < 0)
					idx = 0;
				if (idx > 4095)
					idx = 4095;
			end else begin
				idx = $urandom_range(0, 4095);
			end
			send(12'(idx), rand_meas(), rand_unc());
		end
	endtask

	initial begin
		logic [31:0] a, c, w;
		int m;
		arst_n = 1'b0;
		start = 1'b0;
		sample_index = '0;
		measured = '0;
		uncertainty = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: peak, near side, far tail, saturation, degenerate sigma
		send(12'd0, 32'h0001_0000, 31'h0001_0000);
		send(12'd1, 32'h0000_8000, 31'h0001_0000);
		send(12'd2, 32'h0000_0000, 31'h0000_4000);
		send(12'd3, 32'hffff_0000, 31'h0001_0000);
		send(12'd4095, 32'h7fff_ffff, 31'd1);
		send(12'd0, 32'h8000_0000, 31'd1);
		send(12'd1, 32'h0000_0000, 31'd0);
		send(12'd0, 32'h0000_0000, 31'h7fff_ffff);
		configure(32'h7fff_ffff, 32'h0800_8000, 32'h7fff_ffff);
		send(12'd2048, 32'h0000_0000, 31'd1);
		send(12'd0, 32'h7fff_ffff, 31'd1);
		send(12'd4095, 32'h8000_0000, 31'h0000_0100);
		configure(32'h8000_0000, 32'h8000_0000, 32'd0);
		cfg_write(REG_SPARE, 32'hdead_beef);
		send(12'd0, 32'h0000_0000, 31'h0001_0000);
		send(12'd4095, 32'h0001_0000, 31'd1);
		configure(32'h8000_0000, 32'h0000_0000, 32'd1);
		send(12'd0, 32'h0000_0000, 31'd1);
		send(12'd1, 32'h0000_0000, 31'd1);
		configure(32'h0003_0000, 32'h7fff_ffff, 32'h0010_0000);
		send(12'd4095, 32'h0001_0000, 31'h0001_0000);
		send(12'd4090, 32'h0000_0000, 31'h0000_1000);
		configure(32'hfffe_0000, 32'h0064_4000, 32'h0002_8000);
		for (int i = 96; i <= 104; i++)
			send(12'(i), 32'h0000_0000, 31'h0001_0000);

		for (int p = 0; p < 10; p++) begin
			gaps_on = (p % 4) != 3;
			m = $urandom_range(0, 3);
			a = (m == 0) ? $urandom : 32'($urandom_range(0, 8 << 16)) - 32'(4 << 16);
			c = {4'b0, 12'($urandom_range(0, 4095)), 16'($urandom)};
			if (m == 1)
				c = $urandom;
			case ($urandom_range(0, 4))
				0: w = 32'($urandom_range(1, 1 << 14));
				1: w = {1'b0, 31'($urandom)};
				default: w = 32'($urandom_range(1 << 15, 64 << 16));
			endcase
			configure(a, c, w);
			random_phase(200);
		end

		drain();
		$display("fed %0d samples over %0d register settings", sent, phases);
		$display("compared %0d results field by field", sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("timeout");
		$display("DONE: errors detected");
		$finish;
	end

endmodule
